/* sv/tset_pkg.sv */
package tset_pkg;

  localparam int NUM_SLIDERS_DEF   = 2;
  localparam int POSITION_BITS_DEF = 15;
  localparam int QUEUE_DEPTH       = 2;

  localparam int POS_W   = 15;
  localparam int AMT_W   = 15;
  localparam int FULL_W  = 15;
  localparam int HALF_W  = 14;
  localparam int WRAP_W  = 2;
  localparam int FLAG_W  = 4;
  localparam int DIR_W   = 2;
  localparam int CFG_W   = 15;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_WRAP_MASK  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FULL_RANGE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HALF_RANGE = 2'd2;

  localparam logic [WRAP_W-1:0] WRAP_RESET = 2'd2;
  localparam logic [FULL_W-1:0] FULL_RESET = 15'd256;
  localparam logic [HALF_W-1:0] HALF_RESET = 14'd128;

  localparam logic [FLAG_W-1:0] EV_PUSHED   = 4'b0001;
  localparam logic [FLAG_W-1:0] EV_RELEASED = 4'b0010;
  localparam logic [FLAG_W-1:0] EV_SLIDE    = 4'b0100;
  localparam logic [FLAG_W-1:0] EV_TOUCH    = 4'b1000;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  localparam logic REQ_SCAN  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic              clr;
    logic              id;
    logic              id_ok;
    logic [POS_W-1:0]  sample;
    logic [FLAG_W-1:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [WRAP_W-1:0] wrap_mask;
    logic [FULL_W-1:0] full_range;
    logic [HALF_W-1:0] half_range;
  } cfg_t;

endpackage

/* sv/tset_front.sv */
module tset_front #(
  parameter int NUM_SLIDERS   = tset_pkg::NUM_SLIDERS_DEF,
  parameter int POSITION_BITS = tset_pkg::POSITION_BITS_DEF
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic                      in_slider_id,
  input  logic [tset_pkg::POS_W-1:0]  in_sample_value,
  input  logic [tset_pkg::FLAG_W-1:0] in_clear_mask,
  input  logic                      q_full,
  output logic                      q_push,
  output tset_pkg::cmd_t            q_cmd
);
  import tset_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd        = '0;
    q_cmd.clr    = (in_req_type == REQ_CLEAR);
    q_cmd.id     = in_slider_id;
    q_cmd.id_ok  = (32'(in_slider_id) < NUM_SLIDERS);
    q_cmd.sample = POS_W'(in_sample_value[POSITION_BITS-1:0]);
    q_cmd.mask   = in_clear_mask;
  end

endmodule

/* sv/tset_queue.sv */
module tset_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tset_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tset_pkg::cmd_t head_cmd
);
  import tset_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* sv/tset_back.sv */
module tset_back #(
  parameter int NUM_SLIDERS   = tset_pkg::NUM_SLIDERS_DEF,
  parameter int POSITION_BITS = tset_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tset_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  tset_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_slider_id,
  output logic [tset_pkg::FLAG_W-1:0] out_event_flags,
  output logic [tset_pkg::AMT_W-1:0]  out_slide_amount,
  output logic [tset_pkg::DIR_W-1:0]  out_direction,
  output logic [tset_pkg::POS_W-1:0]  out_position
);
  import tset_pkg::*;

  localparam int IDX_W = (NUM_SLIDERS > 1) ? $clog2(NUM_SLIDERS) : 1;
  localparam int PB    = POSITION_BITS;

  logic [PB-1:0]     prev_pos_r [NUM_SLIDERS];
  logic [PB-1:0]     cur_pos_r  [NUM_SLIDERS];
  logic [FLAG_W-1:0] events_r   [NUM_SLIDERS];
  logic [AMT_W-1:0]  amount_r   [NUM_SLIDERS];
  logic [DIR_W-1:0]  dir_r      [NUM_SLIDERS];

  logic              out_valid_r;
  logic              out_id_r;
  logic [FLAG_W-1:0] out_flags_r;
  logic [AMT_W-1:0]  out_amt_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic [POS_W-1:0]  out_pos_r;

  logic [IDX_W-1:0]  idx;
  logic              wrap;
  logic [PB-1:0]     prev, cur;
  logic signed [16:0] d, h, f, a;
  logic [16:0]       a_abs;
  logic              seam;
  logic [PB-1:0]     prev_nxt;
  logic [FLAG_W-1:0] events_nxt;
  logic [AMT_W-1:0]  amount_nxt;
  logic [DIR_W-1:0]  dir_nxt;
  logic              take;

  assign take  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  assign idx  = IDX_W'(q_cmd.id);
  assign wrap = cfg.wrap_mask[q_cmd.id];
  assign prev = prev_pos_r[idx];
  assign cur  = q_cmd.sample[PB-1:0];

  always_comb begin
    d     = signed'(17'(prev)) - signed'(17'(cur));
    h     = signed'(17'(cfg.half_range));
    f     = signed'(17'(cfg.full_range));
    seam  = wrap && ((d > h) || (d < -h));
    a     = d;
    if (wrap && (d > h)) begin
      a = d - f;
    end else if (wrap && (d < -h)) begin
      a = d + f;
    end
    a_abs = (a < 0) ? 17'(-a) : 17'(a);

    prev_nxt   = prev;
    events_nxt = events_r[idx];
    amount_nxt = amount_r[idx];
    dir_nxt    = dir_r[idx];
    if (q_cmd.clr) begin
      events_nxt = events_r[idx] & ~q_cmd.mask;
    end else if (prev != cur) begin
      prev_nxt = cur;
      if (prev == '0) begin
        events_nxt = events_r[idx] | EV_PUSHED;
      end else if (cur == '0) begin
        events_nxt = events_r[idx] | EV_RELEASED;
      end else begin
        events_nxt = events_r[idx] | EV_SLIDE;
        amount_nxt = a_abs[AMT_W-1:0];
        if (!seam) begin
          dir_nxt = (prev < cur) ? DIR_UP : DIR_DOWN;
        end
      end
    end else begin
      if (cur != '0) begin
        events_nxt = events_r[idx] | EV_TOUCH;
      end
      dir_nxt = DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLIDERS; i++) begin
        prev_pos_r[i] <= '0;
        cur_pos_r[i]  <= '0;
        events_r[i]   <= '0;
        amount_r[i]   <= '0;
        dir_r[i]      <= DIR_NONE;
      end
    end else if (take && q_cmd.id_ok) begin
      prev_pos_r[idx] <= prev_nxt;
      events_r[idx]   <= events_nxt;
      amount_r[idx]   <= amount_nxt;
      dir_r[idx]      <= dir_nxt;
      if (!q_cmd.clr) begin
        cur_pos_r[idx] <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_id_r <= q_cmd.id;
      if (q_cmd.id_ok) begin
        out_flags_r <= events_nxt;
        out_amt_r   <= amount_nxt;
        out_dir_r   <= dir_nxt;
        out_pos_r   <= q_cmd.clr ? POS_W'(cur_pos_r[idx]) : POS_W'(cur);
      end else begin
        out_flags_r <= '0;
        out_amt_r   <= '0;
        out_dir_r   <= DIR_NONE;
        out_pos_r   <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slider_id    = out_id_r;
  assign out_event_flags  = out_flags_r;
  assign out_slide_amount = out_amt_r;
  assign out_direction    = out_dir_r;
  assign out_position     = out_pos_r;

  a_scan_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_cmd.id_ok && !q_cmd.clr && q_cmd.sample[PB-1:0] != '0) |=>
      ((out_event_flags & (EV_PUSHED | EV_SLIDE | EV_TOUCH)) != '0))
    else $error("touched scan left no flag set");

  a_clear_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_cmd.id_ok && q_cmd.clr) |=>
      ((out_event_flags & $past(q_cmd.mask)) == '0))
    else $error("cleared flag still set");

  a_bad_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !q_cmd.id_ok) |=>
      (out_event_flags == '0 && out_slide_amount == '0 &&
       out_direction == DIR_NONE && out_position == '0))
    else $error("unknown slider gave nonzero word");

endmodule

/* sv/touch_slider_event_tracker_unit.sv */
// Channel   Handshake               Payload
// in        in_valid / in_stall     in_req_type, in_slider_id, in_sample_value, in_clear_mask
// out       out_valid / out_stall   out_slider_id, out_event_flags, out_slide_amount,
//                                   out_direction, out_position
// cfg       cfg_we                  cfg_index, cfg_wdata
//
// One word per cycle sustained while out_stall is low; a result appears in the cycle after
// the back end pops it, after passing the queue stage and then the output register.
// Per-slider state is read, updated and written back in the back-end cycle.
// 2-entry queue decouples input from a stalled output; in_stall rises when it fills.
// Synchronous active-low reset clears slider state, queue and config to defaults.
module touch_slider_event_tracker_unit #(
  parameter int NUM_SLIDERS   = tset_pkg::NUM_SLIDERS_DEF,
  parameter int POSITION_BITS = tset_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic                        in_slider_id,
  input  logic [tset_pkg::POS_W-1:0]  in_sample_value,
  input  logic [tset_pkg::FLAG_W-1:0] in_clear_mask,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_slider_id,
  output logic [tset_pkg::FLAG_W-1:0] out_event_flags,
  output logic [tset_pkg::AMT_W-1:0]  out_slide_amount,
  output logic [tset_pkg::DIR_W-1:0]  out_direction,
  output logic [tset_pkg::POS_W-1:0]  out_position,
  input  logic                        cfg_we,
  input  logic [tset_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tset_pkg::CFG_W-1:0]  cfg_wdata
);
  import tset_pkg::*;

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_mask  <= WRAP_RESET;
      cfg_r.full_range <= FULL_RESET;
      cfg_r.half_range <= HALF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_MASK:  cfg_r.wrap_mask  <= cfg_wdata[WRAP_W-1:0];
        REG_FULL_RANGE: cfg_r.full_range <= cfg_wdata[FULL_W-1:0];
        REG_HALF_RANGE: cfg_r.half_range <= cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  tset_front #(
    .NUM_SLIDERS  (NUM_SLIDERS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_slider_id   (in_slider_id),
    .in_sample_value(in_sample_value),
    .in_clear_mask  (in_clear_mask),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  tset_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (head_cmd)
  );

  tset_back #(
    .NUM_SLIDERS  (NUM_SLIDERS),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slider_id   (out_slider_id),
    .out_event_flags (out_event_flags),
    .out_slide_amount(out_slide_amount),
    .out_direction   (out_direction),
    .out_position    (out_position)
  );

endmodule

/* dv/slider_event_checker.sv */
module slider_event_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_req_type,
  input  logic                          in_slider_id,
  input  logic [tset_pkg::POS_W-1:0]    in_sample_value,
  input  logic [tset_pkg::FLAG_W-1:0]   in_clear_mask,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_slider_id,
  input  logic [tset_pkg::FLAG_W-1:0]   out_event_flags,
  input  logic [tset_pkg::AMT_W-1:0]    out_slide_amount,
  input  logic [tset_pkg::DIR_W-1:0]    out_direction,
  input  logic [tset_pkg::POS_W-1:0]    out_position,
  input  logic                          cfg_we,
  input  logic [tset_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tset_pkg::CFG_W-1:0]    cfg_wdata,
  output int                            mismatches,
  output int                            outstanding
);
  import tset_pkg::*;

  typedef struct packed {
    logic              id;
    logic [FLAG_W-1:0] flags;
    logic [AMT_W-1:0]  amount;
    logic [DIR_W-1:0]  dir;
    logic [POS_W-1:0]  pos;
  } slider_report_t;

  slider_report_t    expected_reports[$];

  logic [WRAP_W-1:0] wrap_cfg;
  logic [FULL_W-1:0] full_cfg;
  logic [HALF_W-1:0] half_cfg;

  logic [POS_W-1:0]  prev_pos[2];
  logic [POS_W-1:0]  cur_pos[2];
  logic [FLAG_W-1:0] sticky[2];
  logic [AMT_W-1:0]  amt[2];
  logic [DIR_W-1:0]  dir[2];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic update_slider(input logic clr, input logic id,
                               input logic [POS_W-1:0] smp,
                               input logic [FLAG_W-1:0] msk,
                               output slider_report_t rpt);
    int d;
    int a;
    int h;
    int f;
    logic seam;
    logic [POS_W-1:0] was;
    was = prev_pos[id];
    h = int'(half_cfg);
    f = int'(full_cfg);
    if (clr == REQ_CLEAR) begin
      sticky[id] &= ~msk;
    end else begin
      cur_pos[id] = smp;
      if (was != smp) begin
        if (was == '0) begin
          sticky[id] |= EV_PUSHED;
        end else if (smp == '0) begin
          sticky[id] |= EV_RELEASED;
        end else begin
          d = int'(was) - int'(smp);
          a = d;
          seam = wrap_cfg[id] && (d > h || d < -h);
          if (wrap_cfg[id]) begin
            if (d > h) a = d - f;
            else if (d < -h) a = d + f;
          end
          if (a < 0) a = -a;
          amt[id] = a[AMT_W-1:0];
          // seam crossing keeps the old direction
          if (!seam) dir[id] = (was < smp) ? DIR_UP : DIR_DOWN;
          sticky[id] |= EV_SLIDE;
        end
        prev_pos[id] = smp;
      end else begin
        if (smp != '0) sticky[id] |= EV_TOUCH;
        dir[id] = DIR_NONE;
      end
    end
    rpt = '{id, sticky[id], amt[id], dir[id], cur_pos[id]};
  endtask

  always @(posedge clk) begin
    slider_report_t want;
    slider_report_t fresh;
    if (!rst_n) begin
      expected_reports.delete();
      outstanding = 0;
      mismatches = 0;
      wrap_cfg = WRAP_RESET;
      full_cfg = FULL_RESET;
      half_cfg = HALF_RESET;
      for (int i = 0; i < 2; i++) begin
        prev_pos[i] = '0;
        cur_pos[i] = '0;
        sticky[i] = '0;
        amt[i] = '0;
        dir[i] = DIR_NONE;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected word, slider", int'(out_slider_id), -1);
        end else begin
          want = expected_reports.pop_front();
          outstanding--;
          if (out_slider_id !== want.id)
            report_mismatch("slider", int'(out_slider_id), int'(want.id));
          if (out_event_flags !== want.flags)
            report_mismatch("flags", int'(out_event_flags), int'(want.flags));
          if (out_slide_amount !== want.amount)
            report_mismatch("amount", int'(out_slide_amount), int'(want.amount));
          if (out_direction !== want.dir)
            report_mismatch("direction", int'(out_direction), int'(want.dir));
          if (out_position !== want.pos)
            report_mismatch("position", int'(out_position), int'(want.pos));
        end
      end
      if (in_valid && !in_stall) begin
        update_slider(in_req_type, in_slider_id, in_sample_value, in_clear_mask, fresh);
        expected_reports.push_back(fresh);
        outstanding++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WRAP_MASK:  wrap_cfg = cfg_wdata[WRAP_W-1:0];
          REG_FULL_RANGE: full_cfg = cfg_wdata[FULL_W-1:0];
          REG_HALF_RANGE: half_cfg = cfg_wdata[HALF_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import tset_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_WORDS = 200;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = REQ_SCAN;
  logic              in_slider_id = 1'b0;
  logic [POS_W-1:0]  in_sample_value = '0;
  logic [FLAG_W-1:0] in_clear_mask = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_slider_id;
  logic [FLAG_W-1:0] out_event_flags;
  logic [AMT_W-1:0]  out_slide_amount;
  logic [DIR_W-1:0]  out_direction;
  logic [POS_W-1:0]  out_position;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_WRAP_MASK;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  int                mismatches;
  int                outstanding;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                quiet_cycles = 0;
  int                full_now = int'(FULL_RESET);
  logic [POS_W-1:0]  last_sample[2] = '{default: '0};

  touch_slider_event_tracker_unit dut (.*);

  slider_event_checker checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic req, input logic id,
                           input logic [POS_W-1:0] smp, input logic [FLAG_W-1:0] msk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_slider_id <= id;
    in_sample_value <= smp;
    in_clear_mask <= msk;
    if (req == REQ_SCAN) last_sample[id] = smp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FULL_RANGE) full_now = int'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed touch motion, some clears and raw noise
  task automatic send_random();
    logic id;
    int span;
    int s;
    int pick;
    id = 1'($urandom_range(1));
    span = (full_now >= 2) ? full_now - 1 : 32767;
    s = int'(last_sample[id]);
    pick = $urandom_range(99);
    if ($urandom_range(99) < 12) begin
      send_word(REQ_CLEAR, id, POS_W'($urandom_range(32767)), FLAG_W'($urandom_range(15)));
    end else begin
      if (pick < 15) begin
        s = 0;
      end else if (pick < 30) begin
        s = int'(last_sample[id]);
      end else if (pick < 55) begin
        s = ($urandom_range(1)) ? s + $urandom_range(1, 8) : s - $urandom_range(1, 8);
        if (s < 1) s += span;
        if (s > span) s -= span;
      end else if (pick < 75) begin
        s = ($urandom_range(1)) ? 1 + $urandom_range(3) : span - $urandom_range(3);
        if (s < 1) s = 1;
      end else if (pick < 90) begin
        s = $urandom_range(span, 1);
      end else begin
        s = $urandom_range(32767);
      end
      send_word(REQ_SCAN, id, s[POS_W-1:0], FLAG_W'($urandom_range(15)));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 13;
    recv_idle_pct = 56;

    // slider 0 is a bar, slider 1 a circle of 256 at reset
    send_word(REQ_SCAN,  1'b0, 15'd0,     4'hf);
    send_word(REQ_SCAN,  1'b0, 15'd32767, 4'h0);
    send_word(REQ_SCAN,  1'b0, 15'd32767, 4'h0);
    send_word(REQ_SCAN,  1'b0, 15'd1,     4'h0);
    send_word(REQ_SCAN,  1'b0, 15'd5,     4'h0);
    send_word(REQ_SCAN,  1'b0, 15'd0,     4'h0);
    send_word(REQ_CLEAR, 1'b0, 15'd32767, 4'hf);
    send_word(REQ_SCAN,  1'b1, 15'd10,    4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd250,   4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd5,     4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd133,   4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd5,     4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd5,     4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd0,     4'h0);
    send_word(REQ_CLEAR, 1'b1, 15'd0,     4'h5);
    send_word(REQ_CLEAR, 1'b1, 15'd0,     4'h0);
    send_word(REQ_CLEAR, 1'b0, 15'd0,     4'ha);
    send_word(REQ_SCAN,  1'b1, 15'd32767, 4'h0);
    send_word(REQ_SCAN,  1'b1, 15'd1,     4'h0);
    send_word(REQ_SCAN,  1'b0, 15'd7,     4'hf);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      if (p < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1: begin
          write_reg(REG_WRAP_MASK, 15'd3);
          write_reg(REG_FULL_RANGE, 15'd256);
          write_reg(REG_HALF_RANGE, 15'd128);
        end
        2: begin
          write_reg(REG_WRAP_MASK, 15'd1);
          write_reg(REG_FULL_RANGE, 15'd32767);
          write_reg(REG_HALF_RANGE, 15'd16383);
        end
        3: begin
          write_reg(REG_WRAP_MASK, 15'd3);
          write_reg(REG_FULL_RANGE, 15'd2);
          write_reg(REG_HALF_RANGE, 15'd1);
        end
        4: begin
          write_reg(REG_WRAP_MASK, 15'd2);
          write_reg(REG_FULL_RANGE, 15'd0);
          write_reg(REG_HALF_RANGE, 15'd0);
        end
        5: begin
          // upper data bits beyond the register width are dropped
          write_reg(REG_WRAP_MASK, 15'h7ffc);
          write_reg(REG_FULL_RANGE, 15'd4096);
          write_reg(REG_HALF_RANGE, 15'h4800);
        end
        default: ;
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2) drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
